FILE: hdl/md5_pkg.sv
// Package for the MD5 stream hasher: constants, tables and round helpers.
// No dependencies.
package md5_pkg;

   localparam int BlockBytes = 64;
   localparam int LenOffset  = 56;
   localparam int BlockWords = 16;

   localparam logic CMD_DATA   = 1'b0;
   localparam logic CMD_FINISH = 1'b1;

   localparam logic [31:0] INIT_A = 32'h67452301;
   localparam logic [31:0] INIT_B = 32'hefcdab89;
   localparam logic [31:0] INIT_C = 32'h98badcfe;
   localparam logic [31:0] INIT_D = 32'h10325476;

   typedef struct packed {
      logic       start;
      logic [3:0] msg_index;
      logic [5:0] round;
   } round_ctl_type;

   function automatic logic [31:0] sine_const(input logic [5:0] r);
      logic [31:0] k;
      case (r)
         6'd0:  k = 32'hd76aa478; 6'd1:  k = 32'he8c7b756; 6'd2:  k = 32'h242070db;
         6'd3:  k = 32'hc1bdceee; 6'd4:  k = 32'hf57c0faf; 6'd5:  k = 32'h4787c62a;
         6'd6:  k = 32'ha8304613; 6'd7:  k = 32'hfd469501; 6'd8:  k = 32'h698098d8;
         6'd9:  k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
         6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
         6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
         6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
         6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
         6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
         6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
         6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
         6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
         6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
         6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
         6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
         6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
         6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
         6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
         6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
         6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
         6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
         default: k = 32'heb86d391;
      endcase
      return k;
   endfunction

   function automatic logic [4:0] rot_amount(input logic [5:0] r);
      logic [4:0] s;
      case ({r[5:4], r[1:0]})
         4'd0:  s = 5'd7;  4'd1:  s = 5'd12; 4'd2:  s = 5'd17; 4'd3:  s = 5'd22;
         4'd4:  s = 5'd5;  4'd5:  s = 5'd9;  4'd6:  s = 5'd14; 4'd7:  s = 5'd20;
         4'd8:  s = 5'd4;  4'd9:  s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
         4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15;
         default: s = 5'd21;
      endcase
      return s;
   endfunction

   function automatic logic [3:0] msg_sel(input logic [5:0] r);
      logic [3:0] g;
      case (r[5:4])
         2'd0:    g = r[3:0];
         2'd1:    g = 4'((r[3:0] << 2) + r[3:0] + 4'd1);
         2'd2:    g = 4'((r[3:0] << 1) + r[3:0] + 4'd5);
         default: g = 4'((r[3:0] << 3) - r[3:0]);
      endcase
      return g;
   endfunction

endpackage

FILE: hdl/md5_stream_hasher.sv
// MD5 stream hasher top level: byte gathering, padding and round sequencer.
// Depends on md5_pkg, md5_ram and md5_round.
//
// Usage: each req_ beat carries req_cmd and req_data_byte. cmd 0 appends
// one message byte; cmd 1 finishes the message. A finish produces four rsp_
// beats, words A..D of the digest (rsp_word_index 0..3, rsp_last on D).
// A data byte leaves req_stall low, except the 64th byte of a block, which starts
// a compression (load, read lead, 64 rounds on the shared round unit, fold);
// req_stall is high meanwhile. A finish writes padding one word per cycle,
// runs one or two compressions, then holds each digest word in the chaining
// registers until taken. rsp_stall freezes the output beat and keeps req_stall
// high. Reset (synchronous) restores the MD5 initial value and a zero byte
// count; the block buffer is not cleared.
module md5_stream_hasher import md5_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_cmd,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [1:0]  rsp_word_index,
   output logic        rsp_last
);
   typedef enum logic [2:0] {
      S_IDLE, S_PAD, S_LEN, S_LOAD, S_RUN, S_FOLD, S_OUT
   } state_type;

   state_type     state_ff;
   logic [63:0]   count_ff;
   logic [31:0]   acc_ff;
   logic [6:0]    rcnt_ff;
   logic [3:0]    pw_ff;
   logic          final_ff, extra_ff;
   logic [1:0]    oidx_ff;
   logic          wr_en;
   logic [3:0]    wr_addr;
   logic [31:0]   wr_data, rd_data, chain_word;
   round_ctl_type ctl;
   logic          step, fold, reinit;
   logic [5:0]    pos;
   logic [63:0]   bits;

   assign pos       = count_ff[5:0];
   assign bits      = count_ff << 3;
   assign req_stall = (state_ff != S_IDLE);
   assign ctl.start = (state_ff == S_LOAD);
   assign ctl.round = 6'(rcnt_ff - 7'd1);
   assign ctl.msg_index = msg_sel(rcnt_ff[5:0]);
   assign step   = (state_ff == S_RUN) && (rcnt_ff != 7'd0);
   assign fold   = (state_ff == S_FOLD);
   assign reinit = (state_ff == S_OUT) && !rsp_stall && (oidx_ff == 2'd3);

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = pos[5:2];
      wr_data = 32'h0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_cmd == CMD_DATA) begin
               wr_en = 1'b1;
               case (pos[1:0])
                  2'd0:    wr_data = {24'h0, req_data_byte};
                  2'd1:    wr_data = {16'h0, req_data_byte, acc_ff[7:0]};
                  2'd2:    wr_data = {8'h0, req_data_byte, acc_ff[15:0]};
                  default: wr_data = {req_data_byte, acc_ff[23:0]};
               endcase
            end else if (req_valid) begin
               wr_en = 1'b1;
               case (pos[1:0])
                  2'd0:    wr_data = 32'h80;
                  2'd1:    wr_data = {16'h0, 8'h80, acc_ff[7:0]};
                  2'd2:    wr_data = {8'h0, 8'h80, acc_ff[15:0]};
                  default: wr_data = {8'h80, acc_ff[23:0]};
               endcase
            end
         end
         S_PAD: begin
            wr_en   = 1'b1;
            wr_addr = pw_ff;
         end
         S_LEN: begin
            wr_en   = 1'b1;
            wr_addr = pw_ff;
            wr_data = pw_ff[0] ? bits[63:32] : bits[31:0];
         end
         default: ;
      endcase
   end

   md5_ram #(.Width(32), .Depth(BlockWords)) u_buf (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(ctl.msg_index), .rd_data(rd_data)
   );

   md5_round u_round (
      .clock(clock), .reset(reset), .ctl(ctl), .step(step), .fold(fold),
      .reinit(reinit), .msg_word(rd_data), .rd_sel(oidx_ff), .chain_word(chain_word)
   );

   // rcnt_ff leads the applied round by one for the registered RAM read
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= 64'h0;
         rcnt_ff   <= 7'd0;
         rsp_valid <= 1'b0;
         oidx_ff   <= 2'd0;
         final_ff  <= 1'b0;
         extra_ff  <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_valid && req_cmd == CMD_DATA) begin
                  acc_ff   <= wr_data;
                  count_ff <= count_ff + 64'd1;
                  final_ff <= 1'b0;
                  if (pos == 6'(BlockBytes - 1)) state_ff <= S_LOAD;
               end else if (req_valid) begin
                  final_ff <= 1'b1;
                  extra_ff <= (pos >= 6'(LenOffset));
                  pw_ff    <= pos[5:2] + 4'd1;
                  if (pos[5:2] == 4'd15) state_ff <= (pos >= 6'(LenOffset)) ? S_LOAD : S_LEN;
                  else if (pos[5:2] >= 4'd13 && pos < 6'(LenOffset)) begin
                     state_ff <= S_LEN;
                     pw_ff    <= 4'd14;
                  end else state_ff <= S_PAD;
               end
            end
            S_PAD: begin
               pw_ff <= pw_ff + 4'd1;
               if (!extra_ff && pw_ff == 4'd13) state_ff <= S_LEN;
               else if (pw_ff == 4'd15) state_ff <= extra_ff ? S_LOAD : S_LEN;
            end
            S_LEN: begin
               pw_ff <= pw_ff + 4'd1;
               if (pw_ff == 4'd15) state_ff <= S_LOAD;
            end
            S_LOAD: begin
               rcnt_ff  <= 7'd0;
               state_ff <= S_RUN;
            end
            S_RUN: begin
               rcnt_ff <= rcnt_ff + 7'd1;
               if (rcnt_ff == 7'd64) state_ff <= S_FOLD;
            end
            S_FOLD: begin
               rcnt_ff <= 7'd0;
               if (!final_ff) state_ff <= S_IDLE;
               else if (extra_ff) begin
                  extra_ff <= 1'b0;
                  pw_ff    <= 4'd0;
                  state_ff <= S_PAD;
               end else begin
                  state_ff  <= S_OUT;
                  oidx_ff   <= 2'd0;
                  rsp_valid <= 1'b1;
               end
            end
            S_OUT: begin
               if (!rsp_stall) begin
                  oidx_ff <= oidx_ff + 2'd1;
                  if (oidx_ff == 2'd3) begin
                     rsp_valid <= 1'b0;
                     state_ff  <= S_IDLE;
                     count_ff  <= 64'h0;
                     final_ff  <= 1'b0;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_digest_word = chain_word;
   assign rsp_word_index  = oidx_ff;
   assign rsp_last        = (oidx_ff == 2'd3);

`ifndef SYNTHESIS
   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> req_stall) else $error("ready while busy");
   a_rsp_only_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (state_ff == S_OUT)) else $error("response outside output");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> ($stable(rsp_digest_word) && $stable(rsp_word_index)))
      else $error("stalled beat changed");
   a_round_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RUN && rcnt_ff == 7'd64) |=> (state_ff == S_FOLD))
      else $error("round count overrun");
`endif
endmodule

FILE: hdl/md5_ram.sv
// Generic simple dual-port RAM (one write port, one read port) with registered read.
// No dependencies.
module md5_ram #(
   parameter int Width = 32,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

FILE: hdl/md5_round.sv
// MD5 round unit: one shared round datapath, working and chaining words.
// Depends on md5_pkg.
module md5_round import md5_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  round_ctl_type ctl,
   input  logic          step,
   input  logic          fold,
   input  logic          reinit,
   input  logic [31:0]   msg_word,
   input  logic [1:0]    rd_sel,
   output logic [31:0]   chain_word
);
   logic [31:0] ch_ff [4];
   logic [31:0] wk_ff [4];
   logic [31:0] f, sum, rot;
   logic [4:0]  s;

   always_comb begin
      case (ctl.round[5:4])
         2'd0:    f = (wk_ff[1] & wk_ff[2]) | (~wk_ff[1] & wk_ff[3]);
         2'd1:    f = (wk_ff[3] & wk_ff[1]) | (~wk_ff[3] & wk_ff[2]);
         2'd2:    f = wk_ff[1] ^ wk_ff[2] ^ wk_ff[3];
         default: f = wk_ff[2] ^ (wk_ff[1] | ~wk_ff[3]);
      endcase
      sum = wk_ff[0] + f + msg_word + sine_const(ctl.round);
      s   = rot_amount(ctl.round);
      rot = (sum << s) | (sum >> (6'd32 - {1'b0, s}));
   end

   assign chain_word = ch_ff[rd_sel];

   always_ff @(posedge clock) begin
      if (reset || reinit) begin
         ch_ff[0] <= INIT_A;
         ch_ff[1] <= INIT_B;
         ch_ff[2] <= INIT_C;
         ch_ff[3] <= INIT_D;
      end else if (fold) begin
         for (int i = 0; i < 4; i++) ch_ff[i] <= ch_ff[i] + wk_ff[i];
      end
      if (ctl.start) begin
         for (int i = 0; i < 4; i++) wk_ff[i] <= ch_ff[i];
      end else if (step) begin
         wk_ff[0] <= wk_ff[3];
         wk_ff[3] <= wk_ff[2];
         wk_ff[2] <= wk_ff[1];
         wk_ff[1] <= wk_ff[1] + rot;
      end
   end
endmodule

FILE: verif/md5_digest_checker.sv
// Watches the md5_stream_hasher channels, predicts each message digest and compares.
// Depends on md5_pkg for the command codes, the block constants and the MD5 initial value.
module md5_digest_checker import md5_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_cmd,
   input  logic [7:0]  req_data_byte,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [31:0] rsp_digest_word,
   input  logic [1:0]  rsp_word_index,
   input  logic        rsp_last,
   output int          mismatches,
   output int          words_pending,
   output int          words_checked,
   output int          msgs_done
);

   typedef struct packed {
      logic [31:0] word;
      logic [1:0]  index;
      logic        last;
   } digest_beat_type;

   localparam logic [31:0] SINE_K [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee, 32'hf57c0faf, 32'h4787c62a,
      32'ha8304613, 32'hfd469501, 32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821, 32'hf61e2562, 32'hc040b340,
      32'h265e5a51, 32'he9b6c7aa, 32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed, 32'ha9e3e905, 32'hfcefa3f8,
      32'h676f02d9, 32'h8d2a4c8a, 32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70, 32'h289b7ec6, 32'heaa127fa,
      32'hd4ef3085, 32'h04881d05, 32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039, 32'h655b59c3, 32'h8f0ccc92,
      32'hffeff47d, 32'h85845dd1, 32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};

   localparam int SHIFTS [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

   logic [31:0]     chain [4];
   logic [31:0]     msg_words [16];
   logic [63:0]     msg_bytes;
   digest_beat_type digest_q [$];

   function automatic void restart_chain();
      chain[0] = INIT_A;
      chain[1] = INIT_B;
      chain[2] = INIT_C;
      chain[3] = INIT_D;
      msg_bytes = '0;
   endfunction

   function automatic void place_byte(input int pos, input logic [7:0] b);
      if (pos % 4 == 0) msg_words[pos / 4] = {24'd0, b};
      else msg_words[pos / 4][8 * (pos % 4) +: 8] = b;
   endfunction

   function automatic void md5_compress();
      logic [31:0] a, b, c, d, f, t;
      int g, s;
      a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
      for (int r = 0; r < 64; r++) begin
         if (r < 16) begin
            f = (b & c) | (~b & d); g = r;
         end else if (r < 32) begin
            f = (d & b) | (~d & c); g = (5 * r + 1) % 16;
         end else if (r < 48) begin
            f = b ^ c ^ d; g = (3 * r + 5) % 16;
         end else begin
            f = c ^ (b | ~d); g = (7 * r) % 16;
         end
         t = a + f + msg_words[g] + SINE_K[r];
         s = SHIFTS[(r / 16) * 4 + r % 4];
         a = d; d = c; c = b;
         b = b + ((t << s) | (t >> (32 - s)));
      end
      chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
   endfunction

   function automatic void accept_beat(input logic cmd, input logic [7:0] b);
      int pos;
      logic [63:0] bits;
      pos = int'(msg_bytes[5:0]);
      if (cmd == CMD_DATA) begin
         place_byte(pos, b);
         msg_bytes++;
         if (pos == BlockBytes - 1) md5_compress();
         return;
      end
      place_byte(pos, 8'h80);
      for (int i = pos + 1; i < BlockBytes; i++) place_byte(i, 8'h00);
      if (pos >= LenOffset) begin
         md5_compress();
         for (int i = 0; i < BlockWords; i++) msg_words[i] = '0;
      end
      bits = msg_bytes << 3;
      msg_words[14] = bits[31:0];
      msg_words[15] = bits[63:32];
      md5_compress();
      for (int i = 0; i < 4; i++) digest_q.push_back('{chain[i], 2'(i), i == 3});
      restart_chain();
   endfunction

   always @(posedge clock) begin
      digest_beat_type exp_beat;
      if (reset) begin
         restart_chain();
         digest_q.delete();
         mismatches <= 0;
         words_checked <= 0;
         msgs_done <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (digest_q.size() == 0) begin
               if (mismatches < 10)
                  $display("unexpected digest beat: word=%h index=%0d last=%b",
                           rsp_digest_word, rsp_word_index, rsp_last);
               mismatches <= mismatches + 1;
            end else begin
               exp_beat = digest_q.pop_front();
               if (exp_beat != {rsp_digest_word, rsp_word_index, rsp_last}) begin
                  if (mismatches < 10)
                     $display("digest mismatch: exp %h/%0d/%b got %h/%0d/%b",
                              exp_beat.word, exp_beat.index, exp_beat.last,
                              rsp_digest_word, rsp_word_index, rsp_last);
                  mismatches <= mismatches + 1;
               end
               words_checked <= words_checked + 1;
            end
         end
         if (req_valid && !req_stall) begin
            accept_beat(req_cmd, req_data_byte);
            if (req_cmd == CMD_FINISH) msgs_done <= msgs_done + 1;
         end
      end
      words_pending <= digest_q.size();
   end

endmodule

FILE: verif/tb_top.sv
// Top of the md5_stream_hasher testbench: clock, reset, message stimulus and verdict.
// Depends on md5_pkg, the hasher RTL and md5_digest_checker.
module tb_top;
   import md5_pkg::*;

   localparam int IdleLimit = 4000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_cmd = CMD_DATA;
   logic [7:0]  req_data_byte = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_digest_word;
   logic [1:0]  rsp_word_index;
   logic        rsp_last;

   int mismatches, words_pending, words_checked, msgs_done;
   int beats_sent = 0;
   int burst_left = 0;
   int idle_cycles = 0;
   int stall_mode = 0;
   int stall_phase = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   md5_stream_hasher u_top (.*);

   md5_digest_checker u_check (.*);

   always @(posedge clock) begin
      stall_phase <= stall_phase + 1;
      if (stall_phase % 64 == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 9) < 3);
         2: rsp_stall <= ($urandom_range(0, 9) < 8);
         default: rsp_stall <= (stall_phase % 8) < 3;
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
         $display("status: fail");
         $finish;
      end
   end

   task automatic send_beat(input logic cmd, input logic [7:0] b);
      int gap;
      req_valid     <= 1'b1;
      req_cmd       <= cmd;
      req_data_byte <= b;
      do @(posedge clock); while (req_stall);
      beats_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 30);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic send_message(input int len, input int pattern);
      for (int i = 0; i < len; i++) begin
         case (pattern)
            0: send_beat(CMD_DATA, 8'h00);
            1: send_beat(CMD_DATA, 8'hff);
            default: send_beat(CMD_DATA, 8'($urandom));
         endcase
      end
      send_beat(CMD_FINISH, 8'($urandom));
   endtask

   initial begin
      int len;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty message finished with a nonzero ignored byte, one extreme byte each, three random bytes
      send_beat(CMD_FINISH, 8'hff);
      send_message(1, 0);
      send_message(1, 1);
      send_message(3, 2);

      while (beats_sent < 250) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: len = $urandom_range(0, 15);
            5:             len = $urandom_range(54, 57);
            6:             len = $urandom_range(62, 65);
            7:             len = $urandom_range(118, 128);
            default:       len = $urandom_range(16, 53);
         endcase
         if (len > 250 - beats_sent) len = 250 - beats_sent;
         send_message(len, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1) : 2);
      end
      req_valid <= 1'b0;

      do @(posedge clock); while (words_pending != 0);
      repeat (200) @(posedge clock);

      $display("covered %0d messages in %0d request beats, padding across block edges",
               msgs_done, beats_sent);
      $display("checked %0d digest words, %0d mismatches", words_checked, mismatches);
      if (mismatches == 0 && words_pending == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
